// ===== rtl/core/integer_to_ascii_radix_unit_macros.svh =====
// Assertion macros shared by the integer to ASCII conversion RTL.
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ITAR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itar assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ITAR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itar assertion failed");

`endif

// ===== rtl/core/itar_pkg.sv =====
// Shared constants, types and helpers for the integer to ASCII conversion unit.
package itar_pkg;

	localparam int WORD_BITS   = 32;
	localparam int DIGIT_W     = 6;
	localparam int DIG_IDX_W   = $clog2(WORD_BITS);
	localparam int DIG_CNT_W   = $clog2(WORD_BITS + 1);
	localparam int STEP_W      = $clog2(WORD_BITS);

	localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [DIGIT_W-1:0] RADIX_DEFAULT = 6'd10;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_A     = 7'h61;
	localparam logic [6:0] CHAR_MINUS = 7'h2d;

	typedef struct packed {
		logic                 start;
		logic [WORD_BITS-1:0] dividend;
		logic [DIGIT_W-1:0]   base;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [WORD_BITS-1:0] quot;
		logic [DIGIT_W-1:0]   rem;
	} div_stat_t;

	function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [6:0] d7;
		d7 = {1'b0, d};
		if (d < 6'd10) begin
			digit_char = CHAR_ZERO + d7;
		end else begin
			digit_char = CHAR_A + d7 - 7'd10;
		end
	endfunction

endpackage

// ===== rtl/core/integer_to_ascii_radix_unit.sv =====
// Top level of the integer to ASCII conversion unit in bases 2 to 36.
`include "integer_to_ascii_radix_unit_macros.svh"

// Converts one 32-bit word per transfer to its ASCII digits, most significant
// first, one character per output transfer; the final character carries tlast.
// Digits above nine are lower-case letters. A minus sign leads only in signed
// mode with base ten and a negative word. A radix outside 2 to 36 is treated as
// ten and every character of that run carries tuser high. Each digit comes
// from the bit-serial divider (one quotient bit a cycle), and each character
// then leaves through the digit stack and the output register, held there
// while the output stalls. A new word is taken once the previous run has been
// handed to the output register.
module integer_to_ascii_radix_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] number
	input  logic [6:0]  s_tuser,   // [5:0] radix, [6] signed_mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] character, [7] zero fill
	output logic        m_tlast,   // last_char
	output logic        m_tuser    // [0] bad_radix
);
	import itar_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]           state_q;
	logic [DIG_CNT_W-1:0] cnt_q;
	logic                 bad_q;
	logic                 neg_q;
	logic [DIGIT_W-1:0]   base_q;

	logic [DIGIT_W-1:0]   digit_mem [WORD_BITS];
	logic [DIGIT_W-1:0]   rd_q;
	logic [DIG_IDX_W-1:0] rd_idx;
	logic                 wr_en;

	logic                 out_valid_q;
	logic [6:0]           out_char_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	div_req_t             div_req;
	div_stat_t            div_stat;

	logic                 in_xfer;
	logic                 slot_free;
	logic [WORD_BITS-1:0] in_val;
	logic [DIGIT_W-1:0]   in_radix;
	logic                 in_bad;
	logic                 in_neg;
	logic [WORD_BITS-1:0] in_mag;
	logic                 quot_zero;

	assign in_xfer   = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign in_val    = WORD_BITS'(s_tdata);
	assign in_radix  = s_tuser[5:0];
	assign in_bad    = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
	assign in_neg    = s_tuser[6] && (in_bad || (in_radix == RADIX_DEFAULT))
	                   && in_val[WORD_BITS-1];
	assign in_mag    = in_neg ? (~in_val + 1'b1) : in_val;
	assign quot_zero = (div_stat.quot == '0);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = div_stat.quot;
		div_req.base     = RADIX_DEFAULT;
		if (in_xfer) begin
			div_req.start    = 1'b1;
			div_req.dividend = in_mag;
			div_req.base     = in_bad ? RADIX_DEFAULT : in_radix;
		end else if (state_q == ST_DIV && div_stat.done && !quot_zero) begin
			div_req.start    = 1'b1;
			div_req.dividend = div_stat.quot;
			div_req.base     = base_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			base_q <= in_bad ? RADIX_DEFAULT : in_radix;
		end
	end

	itar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			bad_q   <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= '0;
						bad_q   <= in_bad;
						neg_q   <= in_neg;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (quot_zero) begin
							state_q <= neg_q ? ST_SIGN : ST_READ;
						end
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= (cnt_q == DIG_CNT_W'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digits come out least significant first; read them back as a stack.
	assign wr_en  = (state_q == ST_DIV) && div_stat.done;
	assign rd_idx = DIG_IDX_W'(cnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_mem[cnt_q[DIG_IDX_W-1:0]] <= div_stat.rem;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= digit_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_SIGN || state_q == ST_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN && slot_free) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
			out_bad_q  <= bad_q;
		end else if (state_q == ST_EMIT && slot_free) begin
			out_char_q <= digit_char(rd_q);
			out_last_q <= (cnt_q == DIG_CNT_W'(1));
			out_bad_q  <= bad_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

	`ITAR_ASSERT_NOW(a_idle_div_quiet, state_q == ST_IDLE, !div_stat.busy)
	`ITAR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= DIG_CNT_W'(WORD_BITS))
	`ITAR_ASSERT_NOW(a_sign_only_neg, state_q == ST_SIGN, neg_q && cnt_q != '0)
	`ITAR_ASSERT_NOW(a_stack_nonempty, state_q == ST_READ || state_q == ST_EMIT, cnt_q != '0)
	`ITAR_ASSERT_NEXT(a_div_restart, state_q == ST_DIV && div_stat.done && !quot_zero,
		div_stat.busy)

endmodule

// ===== rtl/core/itar_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
module itar_div (
	input  logic                clk,
	input  logic                arst_n,
	input  itar_pkg::div_req_t  req,
	output itar_pkg::div_stat_t stat
);
	import itar_pkg::*;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] shift_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [DIGIT_W-1:0]   base_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIGIT_W:0]     trial;
	logic                 fits;
	logic [DIGIT_W:0]     diff;

	assign trial = {rem_q, shift_q[WORD_BITS-1]};
	assign fits  = (trial >= {1'b0, base_q});
	assign diff  = trial - {1'b0, base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q <= req.dividend;
			rem_q   <= '0;
			base_q  <= req.base;
		end else if (busy_q) begin
			shift_q <= {shift_q[WORD_BITS-2:0], fits};
			rem_q   <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = shift_q;
	assign stat.rem  = rem_q;

endmodule
